@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant that must hold at every edge out of reset.
`define DQ_INVARIANT(label, expr, msg) \
  `DQ_ASSERT(label, (expr), msg)

`endif

@@ hdl/dq_pkg.sv @@
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_PEEK       = 3'd5
  } dq_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dq_status_t;

  // What a row of cells does this cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS_HEAD,
    OP_ADD_TAIL,
    OP_DEL_HEAD,
    OP_DEL_TAIL,
    OP_CLEAR
  } dq_op_t;

  typedef struct packed {
    logic                     valid;
    logic signed [WORD_W-1:0] word;
  } dq_slot_t;

endpackage

@@ hdl/dq_if.sv @@
`timescale 1ns / 1ps

interface dq_in_if;
  logic                             valid;
  logic                             ready;
  logic [dq_pkg::CMD_W-1:0]         cmd;
  logic signed [dq_pkg::WORD_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dq_out_if #(
  parameter int CNT_W = 5
);
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::WORD_W-1:0] front_word;
  logic signed [dq_pkg::WORD_W-1:0] rear_word;
  logic [CNT_W-1:0]                 count;
  logic                             is_empty;
  logic [dq_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output front_word, output rear_word, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input front_word, input rear_word, input count,
                  input is_empty, input status, output ready);
endinterface

@@ hdl/dq_cell.sv @@
`timescale 1ns / 1ps

module dq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::dq_op_t                   op,
  input  logic signed [dq_pkg::WORD_W-1:0] value,
  input  dq_pkg::dq_slot_t                 left,
  input  dq_pkg::dq_slot_t                 right,
  output dq_pkg::dq_slot_t                 slot
);

  dq_pkg::dq_slot_t slot_r;
  dq_pkg::dq_slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    unique case (op)
      dq_pkg::OP_INS_HEAD: slot_nxt = left;
      dq_pkg::OP_ADD_TAIL: begin
        if (left.valid && !slot_r.valid) begin
          slot_nxt.valid = 1'b1;
          slot_nxt.word  = value;
        end
      end
      dq_pkg::OP_DEL_HEAD: slot_nxt = right;
      dq_pkg::OP_DEL_TAIL: begin
        if (slot_r.valid && !right.valid) begin
          slot_nxt.valid = 1'b0;
        end
      end
      dq_pkg::OP_CLEAR: slot_nxt.valid = 1'b0;
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.word <= slot_nxt.word;
  end

  assign slot = slot_r;

endmodule

@@ hdl/dq_chain.sv @@
`timescale 1ns / 1ps

module dq_chain #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dq_pkg::dq_op_t                   op,
  input  logic signed [dq_pkg::WORD_W-1:0] value,
  output dq_pkg::dq_slot_t                 head
);

  dq_pkg::dq_slot_t slots [DEPTH];
  dq_pkg::dq_slot_t lefts [DEPTH];
  dq_pkg::dq_slot_t rights[DEPTH];

  // Head cell takes the new word from outside; tail cell sees an empty neighbor.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        lefts[i].valid = 1'b1;
        lefts[i].word  = value;
      end else begin
        lefts[i] = slots[i-1];
      end
      if (i == DEPTH - 1) begin
        rights[i].valid = 1'b0;
        rights[i].word  = '0;
      end else begin
        rights[i] = slots[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .value (value),
      .left  (lefts[g]),
      .right (rights[g]),
      .slot  (slots[g])
    );
  end

  assign head = slots[0];

endmodule

@@ hdl/double_ended_queue_top.sv @@
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed 32-bit words. One command item is taken per
// cycle; its result (front and rear words, count, empty flag, status) shows
// on the output in the cycle after, and the next item is taken in the same
// cycle as that result is taken, so the rate is one item per cycle while the
// output is drained. in ready drops only while a result waits unread. The
// words live in two rows of DEPTH cells; inserting or deleting at the first
// cell shifts a row one place. One row is ordered from the front, one from
// the rear, so both end words come straight from the first cell of a row.
// The out count port is $clog2(DEPTH+1) bits wide. Push when full reports
// overflow and pop when empty underflow; both leave the queue unchanged.
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  dq_in_if.sink           in_if,
  dq_out_if.source        out_if
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                   in_acc;
  dq_pkg::dq_cmd_t        cmd_e;
  logic                   full;
  logic                   empty;
  dq_pkg::dq_op_t         front_op;
  dq_pkg::dq_op_t         rear_op;
  dq_pkg::dq_slot_t       front_head;
  dq_pkg::dq_slot_t       rear_head;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  dq_pkg::dq_status_t     status_r;
  dq_pkg::dq_status_t     status_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   push_f_ok;
  logic                   push_r_ok;
  logic                   rows_agree;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cmd_e       = dq_pkg::dq_cmd_t'(in_if.cmd);
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  // Front row is ordered front first, rear row rear first.
  always_comb begin
    front_op   = dq_pkg::OP_HOLD;
    rear_op    = dq_pkg::OP_HOLD;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    if (in_acc) begin
      unique case (cmd_e)
        dq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = dq_pkg::ST_OVERFLOW;
          end else begin
            front_op  = dq_pkg::OP_INS_HEAD;
            rear_op   = dq_pkg::OP_ADD_TAIL;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        dq_pkg::CMD_PUSH_REAR: begin
          if (full) begin
            status_nxt = dq_pkg::ST_OVERFLOW;
          end else begin
            front_op  = dq_pkg::OP_ADD_TAIL;
            rear_op   = dq_pkg::OP_INS_HEAD;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        dq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_nxt = dq_pkg::ST_UNDERFLOW;
          end else begin
            front_op  = dq_pkg::OP_DEL_HEAD;
            rear_op   = dq_pkg::OP_DEL_TAIL;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        dq_pkg::CMD_POP_REAR: begin
          if (empty) begin
            status_nxt = dq_pkg::ST_UNDERFLOW;
          end else begin
            front_op  = dq_pkg::OP_DEL_TAIL;
            rear_op   = dq_pkg::OP_DEL_HEAD;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        dq_pkg::CMD_CLEAR: begin
          front_op  = dq_pkg::OP_CLEAR;
          rear_op   = dq_pkg::OP_CLEAR;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= dq_pkg::ST_OK;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        status_r <= status_nxt;
      end
    end
  end

  dq_chain #(.DEPTH(DEPTH)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (front_op),
    .value (in_if.value),
    .head  (front_head)
  );

  dq_chain #(.DEPTH(DEPTH)) u_rear (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (rear_op),
    .value (in_if.value),
    .head  (rear_head)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.front_word = front_head.valid ? front_head.word : '1;
  assign out_if.rear_word  = rear_head.valid ? rear_head.word : '1;
  assign out_if.count      = count_r;
  assign out_if.is_empty   = empty;
  assign out_if.status     = status_r;

  assign push_f_ok  = in_acc && (cmd_e == dq_pkg::CMD_PUSH_FRONT) && !full;
  assign push_r_ok  = in_acc && (cmd_e == dq_pkg::CMD_PUSH_REAR) && !full;
  assign rows_agree = (front_head.valid == rear_head.valid) && (front_head.valid == !empty);

  `DQ_INVARIANT(a_count_bound, count_r <= CNT_W'(DEPTH), "count above depth")
  `DQ_INVARIANT(a_heads_match, rows_agree, "rows disagree with count")
  `DQ_ASSERT(a_push_front, push_f_ok |=> front_head.word == $past(in_if.value), "front word lost")
  `DQ_ASSERT(a_push_rear, push_r_ok |=> rear_head.word == $past(in_if.value), "rear word lost")

endmodule

@@ bench/deque_checker.sv @@
`timescale 1ns / 1ps

module deque_checker #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic clk,
  input  logic rst_n,
  dq_in_if     in_mon,
  dq_out_if    out_mon,
  output int   mismatches,
  output int   awaiting
);
  import dq_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic [STATUS_W-1:0]      status;
  } deque_view_t;

  logic signed [WORD_W-1:0] ring [DEPTH];
  int unsigned              head_ptr;
  int unsigned              fill;
  deque_view_t              pending_views[$];
  int                       fails = 0;
  int                       waiting = 0;

  assign mismatches = fails;
  assign awaiting   = waiting;

  function automatic deque_view_t apply_command(logic [CMD_W-1:0] cmd,
                                                logic signed [WORD_W-1:0] word);
    deque_view_t v;
    v.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
          ring[head_ptr] = word;
          fill++;
        end
      end
      CMD_PUSH_REAR: begin
        if (fill >= DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          ring[(head_ptr + fill) % DEPTH] = word;
          fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (fill == 0) begin
          v.status = ST_UNDERFLOW;
        end else begin
          head_ptr = (head_ptr + 1) % DEPTH;
          fill--;
        end
      end
      CMD_POP_REAR: begin
        if (fill == 0) v.status = ST_UNDERFLOW;
        else fill--;
      end
      CMD_CLEAR: begin
        head_ptr = 0;
        fill = 0;
      end
      default: ;
    endcase
    if (fill == 0) begin
      v.front_word = '1;
      v.rear_word  = '1;
    end else begin
      v.front_word = ring[head_ptr];
      v.rear_word  = ring[(head_ptr + fill - 1) % DEPTH];
    end
    v.count    = CNT_W'(fill);
    v.is_empty = (fill == 0);
    return v;
  endfunction

  always @(posedge clk) begin
    deque_view_t got;
    deque_view_t want;
    if (!rst_n) begin
      head_ptr = 0;
      fill = 0;
      pending_views.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.front_word = out_mon.front_word;
        got.rear_word  = out_mon.rear_word;
        got.count      = out_mon.count;
        got.is_empty   = out_mon.is_empty;
        got.status     = out_mon.status;
        if (pending_views.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: front %0d rear %0d count %0d empty %0b status %0d",
                     got.front_word, got.rear_word, got.count, got.is_empty, got.status);
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected front %0d rear %0d count %0d empty %0b status %0d",
                       want.front_word, want.rear_word, want.count, want.is_empty,
                       want.status);
              $display("          actual   front %0d rear %0d count %0d empty %0b status %0d",
                       got.front_word, got.rear_word, got.count, got.is_empty, got.status);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_views.push_back(apply_command(in_mon.cmd, in_mon.value));
    end
    waiting = pending_views.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ITEMS = 1950;
  localparam int LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   mismatches;
  int   awaiting;

  dq_in_if                  in_ch ();
  dq_out_if #(.CNT_W(CNT_W)) out_ch ();

  double_ended_queue_top #(.DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  deque_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '1;
      3: return '0;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // push_pct steers the fill level toward full or empty
  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return CMD_CLEAR;
    if (r < 6) begin
      case ($urandom_range(0, 2))
        0: return CMD_PEEK;
        1: return CMD_SPARE_A;
        default: return CMD_SPARE_B;
      endcase
    end
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] word);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) hold = gap_len();
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int push_pct;
    int phase;
    in_ch.valid = 1'b0;
    in_ch.cmd   = CMD_PEEK;
    in_ch.value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue, underflow, extreme words, unused codes
    send_item(CMD_PEEK, $urandom);
    send_item(CMD_POP_FRONT, $urandom);
    send_item(CMD_POP_REAR, $urandom);
    send_item(CMD_PUSH_FRONT, WORD_MIN);
    send_item(CMD_PUSH_REAR, WORD_MAX);
    send_item(CMD_PUSH_FRONT, '1);
    send_item(CMD_POP_FRONT, $urandom);
    send_item(CMD_POP_REAR, $urandom);
    send_item(CMD_SPARE_A, $urandom);
    // fill to full from one entry, then refused pushes
    repeat (DEPTH - 1) send_item(CMD_PUSH_REAR, pick_word());
    send_item(CMD_PUSH_FRONT, '0);
    send_item(CMD_PUSH_REAR, '0);
    send_item(CMD_CLEAR, $urandom);

    sent = 0;
    phase = 0;
    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      burst = $urandom_range(40, 120);
      repeat (burst) begin
        send_item(pick_cmd(push_pct), pick_word());
        sent++;
      end
      phase++;
      if (phase % 5 == 2) drain();
    end
    calm = 1'b0;

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ double_ended_queue_top.f @@
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_cell.sv
hdl/dq_chain.sv
hdl/double_ended_queue_top.sv
bench/deque_checker.sv
bench/tb_top.sv
